>>> hw/rtl/ifsc_pkg.sv
// shared types, constants and codes for the indexed frame scroll/clear engine
`timescale 1ns / 1ps

package ifsc_pkg;

   localparam int WIDTH       = 256;
   localparam int HEIGHT      = 160;
   localparam int FRAME_SIZE  = WIDTH * HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_SIZE);
   localparam int X_W         = $clog2(WIDTH);
   localparam int Y_W         = $clog2(HEIGHT);
   localparam int SIZE_W      = 11;
   localparam int SHIFT_W     = 5;
   localparam int SHIFT_LIMIT = 16;
   localparam int DATA_W      = 8;

   typedef enum logic [1:0] {
      ACT_REG_READ    = 2'd0,
      ACT_REG_WRITE   = 2'd1,
      ACT_PIXEL_READ  = 2'd2,
      ACT_PIXEL_WRITE = 2'd3
   } action_type;

   localparam logic SEL_ARGUMENT = 1'b0;
   localparam logic SEL_COMMAND  = 1'b1;

   localparam logic [7:0] CMD_NOP        = 8'h00;
   localparam logic [7:0] CMD_FILL       = 8'h01;
   localparam logic [7:0] CMD_NOP_2      = 8'h02;
   localparam logic [7:0] CMD_NOP_3      = 8'h03;
   localparam logic [7:0] CMD_ROT_LEFT   = 8'h04;
   localparam logic [7:0] CMD_ROT_RIGHT  = 8'h05;
   localparam logic [7:0] CMD_ROT_UP     = 8'h06;
   localparam logic [7:0] CMD_ROT_DOWN   = 8'h07;
   localparam logic [7:0] CMD_NOP_8      = 8'h08;
   localparam logic [7:0] CMD_ERROR_MARK = 8'h00;

   typedef enum logic [1:0] {
      MODE_FILL = 2'd0,
      MODE_ROW  = 2'd1,
      MODE_COL  = 2'd2
   } sweep_mode_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_MOD   = 3'd1,
      PH_PREP  = 3'd2,
      PH_RUN   = 3'd3,
      PH_DRAIN = 3'd4
   } sweep_phase_type;

   typedef enum logic [1:0] {
      ST_INIT  = 2'd0,
      ST_IDLE  = 2'd1,
      ST_PREAD = 2'd2,
      ST_SWEEP = 2'd3
   } engine_state_type;

   typedef struct packed {
      logic              busy;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_copy;
      logic              flip;
   } sweep_ctl_type;

endpackage

>>> hw/rtl/ifsc_frame_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps

module ifsc_frame_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ifsc_sweep.sv
// address sequencer for fill and rotate sweeps over the frame store
`timescale 1ns / 1ps

module ifsc_sweep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  ifsc_pkg::sweep_mode_type        mode,
   input  logic                            reverse,
   input  logic [ifsc_pkg::SHIFT_W-1:0]    shift,
   output ifsc_pkg::sweep_ctl_type         ctl
);

   import ifsc_pkg::*;

   sweep_phase_type   phase_ff, phase_in;
   sweep_mode_type    mode_ff, mode_in;
   logic              reverse_ff, reverse_in;
   logic [SHIFT_W-1:0] sh_ff, sh_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic [X_W-1:0]    sx_ff, sx_in;
   logic [X_W-1:0]    rs_ff, rs_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;

   logic [SIZE_W-1:0] size;
   logic [SIZE_W-1:0] eff;
   logic [ADDR_W:0]   base_next;
   logic [ADDR_W:0]   base_prod;
   logic              row_end;
   logic              last;
   logic              running;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wr_pend_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      reverse_ff <= reverse_in;
      sh_ff      <= sh_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      sx_ff      <= sx_in;
      rs_ff      <= rs_in;
      dst_ff     <= dst_in;
      base_ff    <= base_in;
      wr_addr_ff <= wr_addr_in;
   end

   assign size      = (mode_ff == MODE_COL) ? SIZE_W'(HEIGHT) : SIZE_W'(WIDTH);
   assign eff       = (reverse_ff && (sh_ff != '0)) ? size - SIZE_W'(sh_ff) : SIZE_W'(sh_ff);
   assign base_prod = (ADDR_W+1)'(eff) * (ADDR_W+1)'(WIDTH);
   assign row_end   = (x_ff == X_W'(WIDTH - 1));
   assign last      = row_end && (y_ff == Y_W'(HEIGHT - 1));
   assign running   = (phase_ff == PH_RUN);

   always_comb begin
      base_next = (ADDR_W+1)'(base_ff) + (ADDR_W+1)'(WIDTH);
      if (base_next >= (ADDR_W+1)'(FRAME_SIZE)) begin
         base_next = base_next - (ADDR_W+1)'(FRAME_SIZE);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      reverse_in = reverse_ff;
      sh_in      = sh_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      sx_in      = sx_ff;
      rs_in      = rs_ff;
      dst_in     = dst_ff;
      base_in    = base_ff;
      wr_pend_in = running && (mode_ff != MODE_FILL);
      wr_addr_in = dst_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mode_in    = mode;
               reverse_in = reverse;
               sh_in      = shift;
               x_in       = '0;
               y_in       = '0;
               sx_in      = '0;
               rs_in      = '0;
               dst_in     = '0;
               base_in    = '0;
               phase_in   = (mode == MODE_FILL) ? PH_RUN : PH_MOD;
            end
         end
         PH_MOD: begin
            // reduce the shift modulo the rotated dimension
            if (SIZE_W'(sh_ff) >= size) begin
               sh_in = SHIFT_W'(SIZE_W'(sh_ff) - size);
            end else begin
               phase_in = PH_PREP;
            end
         end
         PH_PREP: begin
            if (mode_ff == MODE_ROW) begin
               rs_in   = X_W'(eff);
               sx_in   = X_W'(eff);
               base_in = '0;
            end else begin
               rs_in   = '0;
               sx_in   = '0;
               base_in = ADDR_W'(base_prod);
            end
            phase_in = PH_RUN;
         end
         PH_RUN: begin
            dst_in = dst_ff + ADDR_W'(1);
            if (row_end) begin
               x_in    = '0;
               y_in    = y_ff + Y_W'(1);
               sx_in   = rs_ff;
               base_in = ADDR_W'(base_next);
            end else begin
               x_in  = x_ff + X_W'(1);
               sx_in = (sx_ff == X_W'(WIDTH - 1)) ? '0 : sx_ff + X_W'(1);
            end
            if (last) begin
               phase_in = (mode_ff == MODE_FILL) ? PH_IDLE : PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.busy    = (phase_ff != PH_IDLE);
      ctl.rd_en   = running && (mode_ff != MODE_FILL);
      ctl.rd_addr = base_ff + ADDR_W'(sx_ff);
      ctl.wr_en   = (running && (mode_ff == MODE_FILL)) || wr_pend_ff;
      ctl.wr_addr = wr_pend_ff ? wr_addr_ff : dst_ff;
      ctl.wr_copy = wr_pend_ff;
      ctl.flip    = (phase_ff == PH_DRAIN);
   end

endmodule

>>> hw/rtl/indexed_frame_scroll_clear_engine_core.sv
// top level: bus decode, registers, ping-pong frame banks and sweep control
`timescale 1ns / 1ps

// command engine over an 8-bit indexed frame of WIDTH x HEIGHT bytes held in two
// ping-pong ram banks, only one of which is the visible frame at any time.
// register reads and writes and pixel writes are answered straight from idle; a
// pixel read first passes through a read state, as the ram read data is
// registered. a fill command (1) writes the visible bank at one pixel per cycle.
// a rotate command (4 left, 5 right, 6 up, 7 down) clamps the argument to 16,
// writes it back, reduces it modulo the rotated dimension by repeated
// subtraction (at 256 x 160 the clamped shift is below both sizes, so nothing is
// subtracted), then copies every pixel from the visible bank into the other bank
// at its rotated position (one ram read and one write per cycle) and swaps banks.
// the sweep rate is set by the single read port of the visible bank. the command
// write transaction's response is posted at once; the next request stalls until
// the sweep ends. after reset a clearing pass zeroes the visible bank, and
// requests stall until it ends.

module indexed_frame_scroll_clear_engine_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic                           req_reg_select,
   input  logic [15:0]                    req_pixel_address,
   input  logic [7:0]                     req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_read_data
);

   import ifsc_pkg::*;

   engine_state_type  state_ff, state_in;
   logic [7:0]        argument_ff, argument_in;
   logic [7:0]        command_ff, command_in;
   logic              act_ff, act_in;
   logic              oor_ff, oor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   sweep_ctl_type     ctl;
   logic              sweep_start;
   sweep_mode_type    sweep_mode;
   logic              sweep_reverse;
   logic [SHIFT_W-1:0] sweep_shift;

   action_type        action;
   logic              accept;
   logic              in_range;
   logic              cmd_known;
   logic [7:0]        cmd_stored;
   logic [7:0]        clamped;
   logic              bus_we;
   logic              bus_re;
   logic              wbank;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              we0, we1;
   logic [7:0]        rd0, rd1;
   logic [7:0]        rdata_act;

   assign action    = action_type'(req_action);
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign in_range  = 32'(req_pixel_address) < 32'(FRAME_SIZE);
   assign clamped   = (argument_ff > 8'(SHIFT_LIMIT)) ? 8'(SHIFT_LIMIT) : argument_ff;

   always_comb begin
      unique case (req_write_data)
         CMD_NOP, CMD_FILL, CMD_NOP_2, CMD_NOP_3, CMD_ROT_LEFT, CMD_ROT_RIGHT,
         CMD_ROT_UP, CMD_ROT_DOWN, CMD_NOP_8: cmd_known = 1'b1;
         default:                             cmd_known = 1'b0;
      endcase
   end

   assign cmd_stored = cmd_known ? req_write_data : CMD_ERROR_MARK;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         argument_ff  <= '0;
         command_ff   <= '0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         argument_ff  <= argument_in;
         command_ff   <= command_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      argument_in   = argument_ff;
      command_in    = command_ff;
      act_in        = ctl.flip ? ~act_ff : act_ff;
      oor_in        = oor_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      sweep_start   = 1'b0;
      sweep_mode    = MODE_FILL;
      sweep_reverse = 1'b0;
      sweep_shift   = SHIFT_W'(clamped);
      bus_we        = 1'b0;
      bus_re        = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            // clearing pass: argument is zero out of reset
            sweep_start = 1'b1;
            state_in    = ST_SWEEP;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_REG_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = (req_reg_select == SEL_COMMAND) ? command_ff : argument_ff;
                  end
                  ACT_REG_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (req_reg_select == SEL_ARGUMENT) begin
                        argument_in = req_write_data;
                        rsp_data_in = req_write_data;
                     end else begin
                        command_in  = cmd_stored;
                        rsp_data_in = cmd_stored;
                        priority case (cmd_stored)
                           CMD_FILL: begin
                              sweep_start = 1'b1;
                              sweep_mode  = MODE_FILL;
                              state_in    = ST_SWEEP;
                           end
                           CMD_ROT_LEFT, CMD_ROT_RIGHT: begin
                              argument_in   = clamped;
                              sweep_start   = 1'b1;
                              sweep_mode    = MODE_ROW;
                              sweep_reverse = (cmd_stored == CMD_ROT_RIGHT);
                              state_in      = ST_SWEEP;
                           end
                           CMD_ROT_UP, CMD_ROT_DOWN: begin
                              argument_in   = clamped;
                              sweep_start   = 1'b1;
                              sweep_mode    = MODE_COL;
                              sweep_reverse = (cmd_stored == CMD_ROT_DOWN);
                              state_in      = ST_SWEEP;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  ACT_PIXEL_READ: begin
                     bus_re   = 1'b1;
                     oor_in   = !in_range;
                     state_in = ST_PREAD;
                  end
                  ACT_PIXEL_WRITE: begin
                     bus_we       = in_range;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = req_write_data;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREAD: begin
            // output slot is free here: it was free when the read was accepted
            rsp_valid_in = 1'b1;
            rsp_data_in  = oor_ff ? 8'h00 : rdata_act;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            if (!ctl.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ifsc_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (sweep_start),
      .mode    (sweep_mode),
      .reverse (sweep_reverse),
      .shift   (sweep_shift),
      .ctl     (ctl)
   );

   // bank steering: fills and bus writes go to the visible bank, copies to the other
   assign wbank     = ctl.wr_copy ? ~act_ff : act_ff;
   assign ram_waddr = ctl.wr_en ? ctl.wr_addr : ADDR_W'(req_pixel_address);
   assign ram_wdata = ctl.wr_copy ? rdata_act : (ctl.wr_en ? argument_ff : req_write_data);
   assign we0       = (ctl.wr_en && !wbank) || (bus_we && !act_ff);
   assign we1       = (ctl.wr_en && wbank) || (bus_we && act_ff);
   assign ram_re    = ctl.rd_en || bus_re;
   assign ram_raddr = ctl.rd_en ? ctl.rd_addr : ADDR_W'(req_pixel_address);
   assign rdata_act = act_ff ? rd1 : rd0;

   ifsc_frame_ram #(
      .DEPTH  (FRAME_SIZE),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd0)
   );

   ifsc_frame_ram #(
      .DEPTH  (FRAME_SIZE),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd1)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // a pixel read always posts its response on leaving the read state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREAD) |=> rsp_valid_ff)
      else $error("pixel read response missing");

   // the sweep never collides with a bus pixel access
   assert property (@(posedge clock) disable iff (reset)
      (ctl.busy || ctl.wr_en) |-> !(bus_we || bus_re))
      else $error("bus access during sweep");

   // a rotate always leaves the argument clamped
   assert property (@(posedge clock) disable iff (reset)
      (sweep_start && (sweep_mode != MODE_FILL)) |=> (argument_ff <= 8'(SHIFT_LIMIT)))
      else $error("argument not clamped after rotate");

   // the command register only ever holds a known code or the error mark
   assert property (@(posedge clock) disable iff (reset)
      command_ff <= CMD_NOP_8)
      else $error("command register holds unknown code");

endmodule

>>> dv/indexed_frame_scroll_clear_engine_core_test.sv
// indexed frame scroll/clear engine test: directed and random bus traffic vs a frame predictor
`timescale 1ns / 1ps

module indexed_frame_scroll_clear_engine_core_test;
   import ifsc_pkg::*;

   // predicts every read_data byte from its own copy of the frame and registers,
   // and holds the predicted bytes until the block returns them in order
   class pixel_bus_scoreboard;
      bit [7:0] pixels [FRAME_SIZE];
      bit [7:0] prior_pixels [FRAME_SIZE];
      bit [7:0] argument;
      bit [7:0] command;
      bit [7:0] awaited_bytes [$];
      int unsigned responses;
      int unsigned bad_reads;

      // one accepted request transaction: update the frame and registers,
      // queue the byte that the response transaction must carry
      function void note_access(action_type act, logic sel, logic [15:0] addr,
                                logic [7:0] data);
         bit [7:0] result;
         bit [7:0] code;
         int unsigned step;
         int unsigned x;
         int unsigned y;
         result = 8'h00;
         case (act)
            ACT_REG_READ: begin
               result = (sel == SEL_COMMAND) ? command : argument;
            end
            ACT_REG_WRITE: begin
               if (sel == SEL_ARGUMENT) begin
                  argument = data;
                  result   = data;
               end else begin
                  code = data;
                  // rotations clamp the argument and write it back first
                  if (code >= CMD_ROT_LEFT && code <= CMD_ROT_DOWN) begin
                     if (argument > SHIFT_LIMIT)
                        argument = 8'(SHIFT_LIMIT);
                     prior_pixels = pixels;
                  end
                  case (code)
                     CMD_NOP, CMD_NOP_2, CMD_NOP_3, CMD_NOP_8: ;
                     CMD_FILL: begin
                        foreach (pixels[i])
                           pixels[i] = argument;
                     end
                     CMD_ROT_LEFT, CMD_ROT_RIGHT: begin
                        step = argument % WIDTH;
                        if (code == CMD_ROT_RIGHT)
                           step = (WIDTH - step) % WIDTH;
                        for (y = 0; y < HEIGHT; y++)
                           for (x = 0; x < WIDTH; x++)
                              pixels[y * WIDTH + x] =
                                 prior_pixels[y * WIDTH + (x + step) % WIDTH];
                     end
                     CMD_ROT_UP, CMD_ROT_DOWN: begin
                        step = argument % HEIGHT;
                        if (code == CMD_ROT_DOWN)
                           step = (HEIGHT - step) % HEIGHT;
                        for (y = 0; y < HEIGHT; y++)
                           for (x = 0; x < WIDTH; x++)
                              pixels[y * WIDTH + x] =
                                 prior_pixels[((y + step) % HEIGHT) * WIDTH + x];
                     end
                     default: code = CMD_ERROR_MARK;
                  endcase
                  command = code;
                  result  = code;
               end
            end
            ACT_PIXEL_READ: begin
               result = (addr < FRAME_SIZE) ? pixels[addr] : 8'h00;
            end
            ACT_PIXEL_WRITE: begin
               if (addr < FRAME_SIZE)
                  pixels[addr] = data;
               result = data;
            end
         endcase
         awaited_bytes.insert(awaited_bytes.size(), result);
      endfunction

      // one accepted response transaction
      function void check_read_data(logic [7:0] actual);
         bit [7:0] expected;
         responses++;
         if (awaited_bytes.size() == 0) begin
            bad_reads++;
            if (bad_reads <= 10)
               $display("response %0d: unexpected read_data %02h, nothing pending",
                        responses, actual);
            return;
         end
         expected = awaited_bytes.pop_front();
         if (actual !== expected) begin
            bad_reads++;
            if (bad_reads <= 10)
               $display("response %0d: read_data expected %02h, got %02h",
                        responses, expected, actual);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_REG_READ;
   logic        req_reg_select = SEL_ARGUMENT;
   logic [15:0] req_pixel_address = 16'h0000;
   logic [7:0]  req_write_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;

   pixel_bus_scoreboard frame_sb = new;

   // set for the last stretch of the run: no idling on either side
   bit quiet = 1'b0;
   int unsigned stall_left = 0;

   // frame addresses that hold written bytes, so reads can aim at real content
   int unsigned marked [$];

   indexed_frame_scroll_clear_engine_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_reg_select    (req_reg_select),
      .req_pixel_address (req_pixel_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response side: check every accepted transaction, then stall in random bursts.
   // both use the values from before the edge, so nothing races the block
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         frame_sb.check_read_data(rsp_read_data);
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0)
            rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14);
         rsp_stall <= 1'b1;
      end
   end

   // present one request transaction and hold it until accepted; valid stays high
   // into the next call unless a random gap follows
   task automatic send_access(action_type act, logic sel, logic [15:0] addr,
                              logic [7:0] data);
      req_valid         <= 1'b1;
      req_action        <= act;
      req_reg_select    <= sel;
      req_pixel_address <= addr;
      req_write_data    <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      frame_sb.note_access(act, sel, addr, data);
      if (act == ACT_PIXEL_WRITE && addr < FRAME_SIZE)
         marked.insert(marked.size(), addr);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // sender holds off until every outstanding response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_sb.awaited_bytes.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      int unsigned pick;
      int unsigned roll;
      int unsigned base;
      int unsigned k;
      int unsigned sweeps_left;
      logic [15:0] addr;
      logic [7:0]  code;

      sweeps_left = 8;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part: reset contents, frame edges, out-of-frame accesses,
      // fill, every rotation, zero shift, clamping, no-op and unknown commands
      send_access(ACT_REG_READ, SEL_ARGUMENT, 16'h0000, 8'h00);
      send_access(ACT_REG_READ, SEL_COMMAND, 16'h0000, 8'h00);
      send_access(ACT_PIXEL_READ, SEL_ARGUMENT, 16'h0000, 8'h00);
      send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000, 8'h3C);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_FILL);
      send_access(ACT_PIXEL_READ, SEL_COMMAND, 16'd100, 8'hFF);
      send_access(ACT_PIXEL_WRITE, SEL_ARGUMENT, 16'h0000, 8'hFF);
      send_access(ACT_PIXEL_WRITE, SEL_COMMAND, 16'(FRAME_SIZE - 1), 8'h80);
      send_access(ACT_PIXEL_WRITE, SEL_ARGUMENT, 16'(WIDTH - 1), 8'h5A);
      send_access(ACT_PIXEL_WRITE, SEL_ARGUMENT, 16'(FRAME_SIZE), 8'h77);
      send_access(ACT_PIXEL_READ, SEL_ARGUMENT, 16'(FRAME_SIZE), 8'h00);
      send_access(ACT_PIXEL_READ, SEL_ARGUMENT, 16'hFFFF, 8'h00);
      // zero shift leaves the frame alone
      send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000, 8'h00);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_ROT_LEFT);
      send_access(ACT_PIXEL_READ, SEL_ARGUMENT, 16'h0000, 8'h00);
      // oversized argument is clamped to the shift limit and written back
      send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000, 8'hC8);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_ROT_RIGHT);
      send_access(ACT_REG_READ, SEL_ARGUMENT, 16'h0000, 8'h00);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_ROT_UP);
      send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000, 8'h03);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_ROT_DOWN);
      send_access(ACT_PIXEL_READ, SEL_ARGUMENT, 16'(16 + 13 * WIDTH), 8'h00);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_NOP_2);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_NOP_3);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_NOP_8);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, 8'hFF);
      send_access(ACT_REG_READ, SEL_COMMAND, 16'h0000, 8'h00);
      send_access(ACT_REG_WRITE, SEL_COMMAND, 16'h0000, CMD_NOP);

      // random part
      for (n = 0; n < 70; n++) begin
         // hold-off with the pipe empty, then a quiet tail with no idling
         if (n == 35)
            drain_responses();
         if (n == 55)
            quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 9) == 0)
               addr = 16'($urandom_range(FRAME_SIZE, 16'hFFFF));
            else
               addr = 16'($urandom_range(0, FRAME_SIZE - 1));
            send_access(ACT_PIXEL_WRITE, 1'($urandom_range(0, 1)), addr,
                        8'($urandom_range(0, 255)));
         end else if (pick < 65) begin
            roll = $urandom_range(0, 9);
            if (roll < 5 && marked.size() != 0) begin
               // near a written byte, where a rotation may have moved it
               base = marked[$urandom_range(0, marked.size() - 1)];
               k = $urandom_range(0, SHIFT_LIMIT);
               case ($urandom_range(0, 4))
                  0: base = base + k;
                  1: base = base + FRAME_SIZE - k;
                  2: base = base + k * WIDTH;
                  3: base = base + FRAME_SIZE - k * WIDTH;
                  default: ;
               endcase
               addr = 16'(base % FRAME_SIZE);
            end else if (roll < 7) begin
               addr = 16'($urandom_range(0, 16'hFFFF));
            end else begin
               addr = 16'($urandom_range(0, FRAME_SIZE - 1));
            end
            send_access(ACT_PIXEL_READ, 1'($urandom_range(0, 1)), addr,
                        8'($urandom_range(0, 255)));
         end else if (pick < 75) begin
            send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'($urandom_range(0, 16'hFFFF)),
                        8'($urandom_range(0, 1) ? $urandom_range(0, 20)
                                                : $urandom_range(0, 255)));
         end else if (pick < 85) begin
            send_access(ACT_REG_READ, 1'($urandom_range(0, 1)),
                        16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)));
         end else begin
            roll = $urandom_range(0, 3);
            if (roll < 2 && sweeps_left != 0) begin
               // well-formed sweep: argument first, then the command
               case ($urandom_range(0, 4))
                  0: code = CMD_FILL;
                  1: code = CMD_ROT_LEFT;
                  2: code = CMD_ROT_RIGHT;
                  3: code = CMD_ROT_UP;
                  default: code = CMD_ROT_DOWN;
               endcase
               sweeps_left--;
               if (code == CMD_FILL)
                  send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000,
                              8'($urandom_range(0, 255)));
               else if ($urandom_range(0, 7) == 0)
                  send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000, 8'hFF);
               else
                  send_access(ACT_REG_WRITE, SEL_ARGUMENT, 16'h0000,
                              8'($urandom_range(0, 20)));
               send_access(ACT_REG_WRITE, SEL_COMMAND, 16'($urandom_range(0, 16'hFFFF)),
                           code);
            end else if (roll < 3) begin
               case ($urandom_range(0, 3))
                  0: code = CMD_NOP;
                  1: code = CMD_NOP_2;
                  2: code = CMD_NOP_3;
                  default: code = CMD_NOP_8;
               endcase
               send_access(ACT_REG_WRITE, SEL_COMMAND, 16'($urandom_range(0, 16'hFFFF)),
                           code);
            end else begin
               // anything above the no-op range is an unknown command
               send_access(ACT_REG_WRITE, SEL_COMMAND, 16'($urandom_range(0, 16'hFFFF)),
                           8'($urandom_range(CMD_NOP_8 + 1, 255)));
            end
         end
      end

      // wind down: no more requests, let every response come home
      req_valid <= 1'b0;
      while (frame_sb.awaited_bytes.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (frame_sb.bad_reads == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog: several times what the clearing pass plus every sweep needs
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/ifsc_pkg.sv
hw/rtl/ifsc_frame_ram.sv
hw/rtl/ifsc_sweep.sv
hw/rtl/indexed_frame_scroll_clear_engine_core.sv
dv/indexed_frame_scroll_clear_engine_core_test.sv
